[rtl/mfea_pkg.sv]
// ---------------------------------------------------------------------------
// mfea_pkg: shared types and constants for the fragment element address core
// Holds the configuration register map, role and element kind codes, the
// tile shape classes and the structs passed between the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mfea_pkg;

  // Field widths.
  localparam int unsigned LANE_W   = 5;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned COORD_W  = 5;
  localparam int unsigned STRIDE_W = 16;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned DIM_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_USE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_KIND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_MAJOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd5;

  // Matrix roles.
  localparam logic [1:0] USE_A   = 2'd0;
  localparam logic [1:0] USE_B   = 2'd1;
  localparam logic [1:0] USE_ACC = 2'd2;

  // Element kinds.
  localparam logic [2:0] KIND_F32 = 3'd0;
  localparam logic [2:0] KIND_F16 = 3'd1;
  localparam logic [2:0] KIND_S32 = 3'd2;
  localparam logic [2:0] KIND_U32 = 3'd3;
  localparam logic [2:0] KIND_S8  = 3'd4;
  localparam logic [2:0] KIND_U8  = 3'd5;

  // Tile dimensions that the shapes recognise.
  localparam logic [DIM_W-1:0] DIM_8  = 7'd8;
  localparam logic [DIM_W-1:0] DIM_16 = 7'd16;
  localparam logic [DIM_W-1:0] DIM_32 = 7'd32;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] ROWS_RESET = 7'd16;
  localparam logic [DIM_W-1:0] COLS_RESET = 7'd8;

  // Tile shape classes.
  typedef enum logic [1:0] {
    SHAPE_NONE      = 2'd0,
    SHAPE_F16X8     = 2'd1,
    SHAPE_I16X8X32  = 2'd2,
    SHAPE_I16X16X32 = 2'd3
  } mfea_shape_t;

  // Current configuration.
  typedef struct packed {
    logic [1:0]          matrix_use;
    logic [DIM_W-1:0]    matrix_rows;
    logic [DIM_W-1:0]    matrix_cols;
    logic [2:0]          element_kind;
    logic                row_major;
    logic [STRIDE_W-1:0] stride;
  } mfea_cfg_t;

  // Element coordinates after the optional swap.
  typedef struct packed {
    logic [COORD_W-1:0] minor;
    logic [COORD_W-1:0] major;
    logic               unknown;
  } mfea_coord_t;

endpackage

`default_nettype wire

[rtl/mma_fragment_element_address_core.sv]
// ---------------------------------------------------------------------------
// mma_fragment_element_address_core: fragment element address generator
// Gives the minor and major index of one fragment element and the major
// offset scaled by the stride, for warp-wide matrix multiply-add tiles.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: a word (in_lane, in_element_index) is taken at a clock
//   edge where start is high and busy is low. busy is never raised, so a
//   new word may be presented on every cycle.
//   Result channel: out_valid is high for exactly one cycle with the result
//   word; the receiver cannot stall and must take it on that cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_wdata; ready is
//   always high. Registers are to be written only while no word is in flight.
//   Pipeline: an accepted word passes the input register, then layout and a
//   5x16 multiply into the result register.
//   Throughput: one word per cycle, set by the two-register pipeline with no
//   shared unit.
//   Reset: synchronous, active low; it clears the pipeline valid flags and
//   returns the configuration to its reset values. Unknown shapes give zero
//   indices and offset with out_unknown_shape set.
// ---------------------------------------------------------------------------
`default_nettype none

module mma_fragment_element_address_core import mfea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [LANE_W-1:0]     in_lane,
  input  wire logic [IDX_W-1:0]      in_element_index,
  // Result channel
  output logic                       out_valid,
  output logic [COORD_W-1:0]         out_minor_index,
  output logic [COORD_W-1:0]         out_major_index,
  output logic [OFFSET_W-1:0]        out_major_offset,
  output logic                       out_unknown_shape,
  // Configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  mfea_cfg_t   cfg;
  mfea_coord_t coord;
  logic        in_fire;

  // Configuration registers.
  mfea_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The pipeline never stalls.
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Input register.
  logic              s1_valid_r;
  logic [LANE_W-1:0] s1_lane_r;
  logic [IDX_W-1:0]  s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lane_r <= in_lane;
      s1_idx_r  <= in_element_index;
    end
  end

  // Layout logic.
  mfea_layout u_layout (
    .cfg           (cfg),
    .lane          (s1_lane_r),
    .element_index (s1_idx_r),
    .coord         (coord)
  );

  // Result register: unknown shapes report zero coordinates.
  logic                out_valid_r;
  logic [COORD_W-1:0]  minor_r, minor_nxt;
  logic [COORD_W-1:0]  major_r, major_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                unknown_r;
  logic [COORD_W+STRIDE_W-1:0] product;

  always_comb begin
    minor_nxt  = coord.unknown ? '0 : coord.minor;
    major_nxt  = coord.unknown ? '0 : coord.major;
    product    = major_nxt * cfg.stride;
    offset_nxt = product[OFFSET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      minor_r   <= minor_nxt;
      major_r   <= major_nxt;
      offset_r  <= offset_nxt;
      unknown_r <= coord.unknown;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_minor_index   = minor_r;
  assign out_major_index   = major_r;
  assign out_major_offset  = offset_r;
  assign out_unknown_shape = unknown_r;

  // Every accepted word produces exactly one result through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ##1 out_valid)
    else $error("accepted word did not produce a result after two cycles");

  // No result appears unless the input register held an accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r))
    else $error("result strobe without an accepted word");

  // An unknown shape reports zero coordinates and offset.
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unknown_shape) |->
      (out_minor_index == '0 && out_major_index == '0 && out_major_offset == '0))
    else $error("unknown shape with non-zero coordinates");

  // A result whose major index is zero has zero offset.
  a_zero_major: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_major_index == '0) |-> (out_major_offset == '0))
    else $error("non-zero offset for major index zero");

endmodule

`default_nettype wire

[rtl/mfea_cfg_regs.sv]
// ---------------------------------------------------------------------------
// mfea_cfg_regs: configuration register file
// Six registers written through a valid/ready channel by index; a write to
// an index beyond the map is accepted and ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module mfea_cfg_regs import mfea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output mfea_cfg_t                  cfg
);

  mfea_cfg_t cfg_r;
  mfea_cfg_t cfg_nxt;
  logic      wr_en;

  // The register file can always take a word.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // Decode the write into the addressed field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        REG_MATRIX_USE:   cfg_nxt.matrix_use   = cfg_wdata[1:0];
        REG_MATRIX_ROWS:  cfg_nxt.matrix_rows  = cfg_wdata[DIM_W-1:0];
        REG_MATRIX_COLS:  cfg_nxt.matrix_cols  = cfg_wdata[DIM_W-1:0];
        REG_ELEMENT_KIND: cfg_nxt.element_kind = cfg_wdata[2:0];
        REG_ROW_MAJOR:    cfg_nxt.row_major    = cfg_wdata[0];
        REG_STRIDE:       cfg_nxt.stride       = cfg_wdata[STRIDE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_use   <= USE_A;
      cfg_r.matrix_rows  <= ROWS_RESET;
      cfg_r.matrix_cols  <= COLS_RESET;
      cfg_r.element_kind <= KIND_F16;
      cfg_r.row_major    <= 1'b0;
      cfg_r.stride       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/mfea_layout.sv]
// ---------------------------------------------------------------------------
// mfea_layout: shape classification and lane/index layout
// Classifies the configured tile into a shape, applies the shape's layout to
// the lane and element index, and swaps row and column for row-major tiles.
// ---------------------------------------------------------------------------
`default_nettype none

module mfea_layout import mfea_pkg::*; (
  input  wire mfea_cfg_t          cfg,
  input  wire logic [LANE_W-1:0]  lane,
  input  wire logic [IDX_W-1:0]   element_index,
  output mfea_coord_t             coord
);

  mfea_shape_t shape;
  logic        is_f;
  logic        is_i;
  logic        r8, r16, r32, c8, c16, c32;

  // Classify the tile from role, dimensions and element kind.
  always_comb begin
    is_f  = (cfg.element_kind == KIND_F32) || (cfg.element_kind == KIND_F16);
    is_i  = (cfg.element_kind == KIND_S32) || (cfg.element_kind == KIND_U32) ||
            (cfg.element_kind == KIND_S8)  || (cfg.element_kind == KIND_U8);
    r8    = (cfg.matrix_rows == DIM_8);
    r16   = (cfg.matrix_rows == DIM_16);
    r32   = (cfg.matrix_rows == DIM_32);
    c8    = (cfg.matrix_cols == DIM_8);
    c16   = (cfg.matrix_cols == DIM_16);
    c32   = (cfg.matrix_cols == DIM_32);
    shape = SHAPE_NONE;
    case (cfg.matrix_use)
      USE_A: begin
        if (r16 && (c8 || c16) && is_f) shape = SHAPE_F16X8;
        else if (r16 && c32 && is_i)    shape = SHAPE_I16X8X32;
      end
      USE_B: begin
        if (r8 && c8 && is_f)                shape = SHAPE_F16X8;
        else if (r16 && (c8 || c16) && is_f) shape = SHAPE_F16X8;
        else if (r32 && c8 && is_i)          shape = SHAPE_I16X8X32;
        else if (r32 && c16 && is_i)         shape = SHAPE_I16X16X32;
      end
      USE_ACC: begin
        if (r16 && (c8 || c16) && is_f) shape = SHAPE_F16X8;
        else if (r16 && c8 && is_i)     shape = SHAPE_I16X8X32;
        else if (r16 && c16 && is_i)    shape = SHAPE_I16X16X32;
      end
      default: shape = SHAPE_NONE;
    endcase
  end

  logic [2:0] grp;
  logic [1:0] tig;
  logic [3:0] i16;
  logic [5:0] row;
  logic [5:0] col;

  // Row and column within the tile; six bits hold the widest float column.
  always_comb begin
    grp = lane[4:2];
    tig = lane[1:0];
    i16 = element_index[3:0];
    row = '0;
    col = '0;
    case (shape)
      SHAPE_F16X8: begin
        if (cfg.matrix_use != USE_B) begin
          row = {3'b000, grp} + (element_index[1] ? 6'd8 : 6'd0);
          col = {3'b000, tig, element_index[0]};
        end else begin
          row = {3'b000, tig, element_index[0]} + (element_index[1] ? 6'd8 : 6'd0);
          col = {3'b000, grp};
        end
        // Each further group of four elements moves eight columns on.
        col = col + {element_index[4:2], 3'b000};
      end
      SHAPE_I16X8X32, SHAPE_I16X16X32: begin
        if (cfg.matrix_use == USE_A) begin
          row = {3'b000, grp} + (i16[2] ? 6'd8 : 6'd0);
          col = {2'b00, tig, i16[1:0]} + (i16[3] ? 6'd16 : 6'd0);
        end else if (cfg.matrix_use == USE_B) begin
          if (shape == SHAPE_I16X8X32) begin
            row = {2'b00, tig, i16[1:0]} + ((i16 >= 4'd4) ? 6'd16 : 6'd0);
            col = {3'b000, grp};
          end else begin
            row = {2'b00, tig, i16[1:0]} + (i16[3] ? 6'd16 : 6'd0);
            col = {3'b000, grp} + (i16[2] ? 6'd8 : 6'd0);
          end
        end else if (shape == SHAPE_I16X8X32) begin
          row = {3'b000, grp} + ((i16 >= 4'd2) ? 6'd8 : 6'd0);
          col = {3'b000, tig, i16[0]};
        end else begin
          row = {3'b000, grp} + (i16[1] ? 6'd8 : 6'd0);
          col = {3'b000, tig, i16[0]} + {1'b0, i16[3:2], 3'b000};
        end
      end
      default: begin
        row = '0;
        col = '0;
      end
    endcase
  end

  // Swap for row-major tiles and wrap to five bits.
  always_comb begin
    coord.unknown = (shape == SHAPE_NONE);
    if (cfg.row_major) begin
      coord.minor = col[COORD_W-1:0];
      coord.major = row[COORD_W-1:0];
    end else begin
      coord.minor = row[COORD_W-1:0];
      coord.major = col[COORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

[test/mfea_address_checker.sv]
// ---------------------------------------------------------------------------
// mfea_address_checker: result checker for the fragment element address core
// Follows configuration writes and accepted input words, predicts each
// result word from its own copy of the registers, and compares the result
// channel with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module mfea_address_checker import mfea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [LANE_W-1:0]     in_lane,
  input  logic [IDX_W-1:0]      in_element_index,
  input  logic                  out_valid,
  input  logic [COORD_W-1:0]    out_minor_index,
  input  logic [COORD_W-1:0]    out_major_index,
  input  logic [OFFSET_W-1:0]   out_major_offset,
  input  logic                  out_unknown_shape,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  typedef struct packed {
    logic [COORD_W-1:0]  minor;
    logic [COORD_W-1:0]  major;
    logic [OFFSET_W-1:0] offset;
    logic                unknown;
  } element_addr_t;

  localparam mfea_cfg_t CFG_AT_RESET = '{
    matrix_use:   USE_A,
    matrix_rows:  ROWS_RESET,
    matrix_cols:  COLS_RESET,
    element_kind: KIND_F16,
    row_major:    1'b0,
    stride:       '0
  };

  mfea_cfg_t     tile_cfg = CFG_AT_RESET;
  element_addr_t expected_addrs[$];
  element_addr_t oldest;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Classifies the tile and applies that shape's lane and index layout.
  function automatic element_addr_t element_address(input mfea_cfg_t c,
                                                    input logic [LANE_W-1:0] lane,
                                                    input logic [IDX_W-1:0] idx);
    mfea_shape_t   shape;
    logic          fp_kind;
    logic          is_int;
    int unsigned   grp;
    int unsigned   tig;
    int unsigned   i4;
    int unsigned   i16;
    int unsigned   row;
    int unsigned   col;
    int unsigned   minor;
    int unsigned   major;
    element_addr_t r;
    fp_kind = c.element_kind <= KIND_F16;
    is_int  = c.element_kind >= KIND_S32 && c.element_kind <= KIND_U8;
    shape   = SHAPE_NONE;
    case (c.matrix_use)
      USE_A: begin
        if (c.matrix_rows == DIM_16 && (c.matrix_cols == DIM_8 || c.matrix_cols == DIM_16)
            && fp_kind)
          shape = SHAPE_F16X8;
        else if (c.matrix_rows == DIM_16 && c.matrix_cols == DIM_32 && is_int)
          shape = SHAPE_I16X8X32;
      end
      USE_B: begin
        if (c.matrix_rows == DIM_8 && c.matrix_cols == DIM_8 && fp_kind)
          shape = SHAPE_F16X8;
        else if (c.matrix_rows == DIM_16 && (c.matrix_cols == DIM_8 || c.matrix_cols == DIM_16)
                 && fp_kind)
          shape = SHAPE_F16X8;
        else if (c.matrix_rows == DIM_32 && c.matrix_cols == DIM_8 && is_int)
          shape = SHAPE_I16X8X32;
        else if (c.matrix_rows == DIM_32 && c.matrix_cols == DIM_16 && is_int)
          shape = SHAPE_I16X16X32;
      end
      USE_ACC: begin
        if (c.matrix_rows == DIM_16 && (c.matrix_cols == DIM_8 || c.matrix_cols == DIM_16)
            && fp_kind)
          shape = SHAPE_F16X8;
        else if (c.matrix_rows == DIM_16 && c.matrix_cols == DIM_8 && is_int)
          shape = SHAPE_I16X8X32;
        else if (c.matrix_rows == DIM_16 && c.matrix_cols == DIM_16 && is_int)
          shape = SHAPE_I16X16X32;
      end
      default: ;
    endcase

    r = '0;
    if (shape == SHAPE_NONE) begin
      r.unknown = 1'b1;
      return r;
    end

    grp = lane >> 2;
    tig = lane & 3;
    if (shape == SHAPE_F16X8) begin
      // Float layout: pairs of elements per lane, further groups of four move 8 columns on.
      i4 = idx & 3;
      if (c.matrix_use != USE_B) begin
        row = grp + ((i4 >= 2) ? 8 : 0);
        col = tig * 2 + (i4 & 1);
      end else begin
        row = tig * 2 + (i4 & 1) + ((i4 >= 2) ? 8 : 0);
        col = grp;
      end
      col = col + (idx >> 2) * 8;
    end else begin
      // Integer layouts repeat every sixteen elements.
      i16 = idx & 15;
      if (c.matrix_use == USE_A) begin
        row = grp + ((i16 & 4) != 0 ? 8 : 0);
        col = tig * 4 + (i16 & 3) + ((i16 >= 8) ? 16 : 0);
      end else if (c.matrix_use == USE_B) begin
        row = tig * 4 + (i16 & 3);
        if (shape == SHAPE_I16X8X32) begin
          row = row + ((i16 >= 4) ? 16 : 0);
          col = grp;
        end else begin
          row = row + ((i16 >= 8) ? 16 : 0);
          col = grp + ((i16 & 4) != 0 ? 8 : 0);
        end
      end else if (shape == SHAPE_I16X8X32) begin
        row = grp + ((i16 >= 2) ? 8 : 0);
        col = tig * 2 + (i16 & 1);
      end else begin
        row = grp + (((i16 & 3) >= 2) ? 8 : 0);
        col = tig * 2 + (i16 & 1) + (i16 >> 2) * 8;
      end
    end

    // Row-major memory swaps the two indices; both wrap at the 5-bit width.
    minor    = c.row_major ? col : row;
    major    = c.row_major ? row : col;
    r.minor  = COORD_W'(minor);
    r.major  = COORD_W'(major);
    r.offset = OFFSET_W'(32'(r.major) * 32'(c.stride));
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Register writes, result comparison and prediction, all on the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      tile_cfg = CFG_AT_RESET;
      expected_addrs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MATRIX_USE:   tile_cfg.matrix_use   = cfg_wdata[1:0];
          REG_MATRIX_ROWS:  tile_cfg.matrix_rows  = cfg_wdata[DIM_W-1:0];
          REG_MATRIX_COLS:  tile_cfg.matrix_cols  = cfg_wdata[DIM_W-1:0];
          REG_ELEMENT_KIND: tile_cfg.element_kind = cfg_wdata[2:0];
          REG_ROW_MAJOR:    tile_cfg.row_major    = cfg_wdata[0];
          REG_STRIDE:       tile_cfg.stride       = cfg_wdata[STRIDE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid) begin
        if (expected_addrs.size() == 0) begin
          report_failure("result word with no word outstanding");
        end else begin
          oldest = expected_addrs.pop_front();
          if (out_minor_index !== oldest.minor)
            report_failure($sformatf("minor index expected %0d, got %0d",
                                     oldest.minor, out_minor_index));
          if (out_major_index !== oldest.major)
            report_failure($sformatf("major index expected %0d, got %0d",
                                     oldest.major, out_major_index));
          if (out_major_offset !== oldest.offset)
            report_failure($sformatf("major offset expected %0d, got %0d",
                                     oldest.offset, out_major_offset));
          if (out_unknown_shape !== oldest.unknown)
            report_failure($sformatf("unknown shape flag expected %0b, got %0b",
                                     oldest.unknown, out_unknown_shape));
        end
      end

      if (start && !busy)
        expected_addrs.push_back(element_address(tile_cfg, in_lane, in_element_index));
    end
    pending = expected_addrs.size();
  end

endmodule

[test/mma_fragment_element_address_core_tb.sv]
// ---------------------------------------------------------------------------
// mma_fragment_element_address_core_tb: testbench for the address core
// Sweeps every tile shape and role with extreme lanes and element indexes,
// then runs phases of random tile settings and random words under varying
// sender gaps; a separate checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module mma_fragment_element_address_core_tb;
  import mfea_pkg::*;

  localparam int unsigned PHASES          = 14;
  localparam int unsigned WORDS_PER_PHASE = 30;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TIMEOUT_CYCLES  = 200000;
  localparam int unsigned VALID_SHAPES    = 11;
  localparam int unsigned DIRECTED_CFGS   = 14;

  // Codes the package leaves unnamed: a spare register slot, a spare role and two odd kinds.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd6;
  localparam logic [1:0]           USE_SPARE  = 2'd3;
  localparam logic [2:0]           KIND_OTHER = 3'd6;
  localparam logic [2:0]           KIND_UNDEF = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [LANE_W-1:0]     in_lane = '0;
  logic [IDX_W-1:0]      in_element_index = '0;
  logic                  out_valid;
  logic [COORD_W-1:0]    out_minor_index;
  logic [COORD_W-1:0]    out_major_index;
  logic [OFFSET_W-1:0]   out_major_offset;
  logic                  out_unknown_shape;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned           mismatches;
  int unsigned           pending;

  always #5 clk = ~clk;

  mma_fragment_element_address_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_lane          (in_lane),
    .in_element_index (in_element_index),
    .out_valid        (out_valid),
    .out_minor_index  (out_minor_index),
    .out_major_index  (out_major_index),
    .out_major_offset (out_major_offset),
    .out_unknown_shape(out_unknown_shape),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  mfea_address_checker addr_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_lane          (in_lane),
    .in_element_index (in_element_index),
    .out_valid        (out_valid),
    .out_minor_index  (out_minor_index),
    .out_major_index  (out_major_index),
    .out_major_offset (out_major_offset),
    .out_unknown_shape(out_unknown_shape),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input mfea_cfg_t c);
    write_register(REG_MATRIX_USE,   CFG_DATA_W'(c.matrix_use));
    write_register(REG_MATRIX_ROWS,  CFG_DATA_W'(c.matrix_rows));
    write_register(REG_MATRIX_COLS,  CFG_DATA_W'(c.matrix_cols));
    write_register(REG_ELEMENT_KIND, CFG_DATA_W'(c.element_kind));
    write_register(REG_ROW_MAJOR,    CFG_DATA_W'(c.row_major));
    write_register(REG_STRIDE,       c.stride);
  endtask

  // Tile settings by number: the recognised shapes first, then three that match none.
  function automatic mfea_cfg_t shape_config(input int unsigned n);
    mfea_cfg_t   c;
    logic [2:0]  float_kind;
    logic [2:0]  int_kind;
    float_kind = $urandom_range(1) ? KIND_F16 : KIND_F32;
    int_kind   = 3'($urandom_range(KIND_U8, KIND_S32));
    c = '0;
    case (n)
      0:  c = '{USE_A,     DIM_16, DIM_8,  float_kind, 1'b0, '0};
      1:  c = '{USE_A,     DIM_16, DIM_16, float_kind, 1'b0, '0};
      2:  c = '{USE_A,     DIM_16, DIM_32, int_kind,   1'b0, '0};
      3:  c = '{USE_B,     DIM_8,  DIM_8,  float_kind, 1'b0, '0};
      4:  c = '{USE_B,     DIM_16, DIM_8,  float_kind, 1'b0, '0};
      5:  c = '{USE_B,     DIM_16, DIM_16, float_kind, 1'b0, '0};
      6:  c = '{USE_B,     DIM_32, DIM_8,  int_kind,   1'b0, '0};
      7:  c = '{USE_B,     DIM_32, DIM_16, int_kind,   1'b0, '0};
      8:  c = '{USE_ACC,   DIM_16, DIM_8,  float_kind, 1'b0, '0};
      9:  c = '{USE_ACC,   DIM_16, DIM_16, int_kind,   1'b0, '0};
      10: c = '{USE_ACC,   DIM_16, DIM_8,  int_kind,   1'b0, '0};
      11: c = '{USE_SPARE, DIM_16, DIM_8,  KIND_F16,   1'b0, '0};
      12: c = '{USE_A,     DIM_16, DIM_8,  KIND_OTHER, 1'b0, '0};
      default: c = '{USE_ACC, 7'd64, 7'd1, KIND_UNDEF, 1'b0, '0};
    endcase
    return c;
  endfunction

  // Mostly recognised shapes; the rest have every field at random.
  function automatic mfea_cfg_t pick_config();
    mfea_cfg_t c;
    if ($urandom_range(9) < 8) begin
      c = shape_config($urandom_range(VALID_SHAPES - 1));
    end else begin
      c.matrix_use   = 2'($urandom_range(3));
      c.matrix_rows  = DIM_W'($urandom_range(127));
      c.matrix_cols  = DIM_W'($urandom_range(127));
      c.element_kind = 3'($urandom_range(7));
    end
    c.row_major = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       c.stride = '0;
      1:       c.stride = '1;
      default: c.stride = STRIDE_W'($urandom_range(65535));
    endcase
    return c;
  endfunction

  // Sends words from one falling edge to the next; directed words alternate extremes.
  task automatic send_words(input int unsigned count, input int unsigned idle_pct,
                            input bit directed);
    for (int unsigned i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start = 1'b0;
        @(negedge clk);
      end
      start = 1'b1;
      if (directed) begin
        in_lane          = i[0] ? '1 : '0;
        in_element_index = i[0] ? '1 : '0;
      end else begin
        in_lane          = LANE_W'($urandom_range(31));
        in_element_index = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(31))
                                                    : IDX_W'($urandom_range(15));
      end
      @(posedge clk);
      while (busy) @(posedge clk);
      @(negedge clk);
    end
    start = 1'b0;
  endtask

  // Waits until every predicted word has come back, then lets the pipeline settle.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("FAIL");
    $finish;
  end

  initial begin
    mfea_cfg_t   c;
    int unsigned idle_pct;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: reset settings, the spare register slot, then every shape.
    send_words(2, 0, 1'b1);
    drain();
    write_register(REG_SPARE, '1);
    for (int unsigned n = 0; n < DIRECTED_CFGS; n++) begin
      c = shape_config(n);
      c.row_major = n[0];
      case (n % 3)
        0:       c.stride = '0;
        1:       c.stride = '1;
        default: c.stride = STRIDE_W'($urandom_range(65535));
      endcase
      load_config(c);
      send_words((n < VALID_SHAPES) ? 2 : 1, 0, 1'b1);
      drain();
    end

    // Random part: new tile settings per phase, rotating the sender gap rate.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 85;
        default: idle_pct = 29;
      endcase
      load_config(pick_config());
      send_words(WORDS_PER_PHASE, idle_pct, 1'b0);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
